FILE: hdl/tgad_pkg.sv
// shared types and constants for the tga stream decoder
`default_nettype none

package tgad_pkg;

  localparam logic [4:0] HDR_LEN       = 5'd18;
  localparam logic [4:0] POS_TYPE      = 5'd2;
  localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
  localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
  localparam logic [4:0] POS_DEPTH     = 5'd16;

  localparam logic [7:0] TYPE_RAW      = 8'd2;
  localparam logic [7:0] TYPE_RLE_RGB  = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [7:0] PKT_REPEAT_MASK = 8'h80;
  localparam logic [7:0] PKT_COUNT_MASK  = 8'h7f;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic ERR_TYPE  = 1'b0;
  localparam logic ERR_DEPTH = 1'b1;

  localparam logic [1:0] FMT_ALPHA = 2'd0;
  localparam logic [1:0] FMT_RGB   = 2'd1;
  localparam logic [1:0] FMT_RGBA  = 2'd2;

  localparam logic [2:0] BPP_ALPHA = 3'd1;
  localparam logic [2:0] BPP_RGB   = 3'd3;
  localparam logic [2:0] BPP_RGBA  = 3'd4;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  pixel_format;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic        last;
  } result_t;

  function automatic logic [1:0] fmt_of(input logic [2:0] bpp);
    logic [1:0] f;
    case (bpp)
      BPP_RGBA: f = FMT_RGBA;
      BPP_RGB:  f = FMT_RGB;
      default:  f = FMT_ALPHA;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tgad_in_stage.sv
// input register stage of the tga stream decoder
`default_nettype none

module tgad_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_file_byte,
  input  wire logic           in_first_byte,
  input  wire logic           advance,
  output logic                item_vld,
  output tgad_pkg::item_t     item
);
  import tgad_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign in_ready = !vld_r || advance;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.file_byte  <= in_file_byte;
      item_r.first_byte <= in_first_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tgad_parser.sv
// header parser and pixel packet decoder, one byte per step
`default_nettype none

module tgad_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire tgad_pkg::item_t  item,
  output logic                  res_vld,
  output tgad_pkg::result_t     res
);
  import tgad_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        idle_r, idle_nxt;
  logic        rle_r, rle_nxt;
  logic [2:0]  bpp_r, bpp_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [31:0] pixels_r, pixels_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic        rep_r, rep_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [23:0] pix_r, pix_nxt;

  logic [7:0]  b;
  logic [4:0]  cur_pos;
  logic        cur_idle;
  logic [7:0]  cnt;
  logic [7:0]  run;
  logic [31:0] pixels_after;
  logic [2:0]  idx_plus;

  assign b        = item.file_byte;
  // a first byte restarts the header parse with this byte as byte zero
  assign cur_pos  = item.first_byte ? 5'd0 : pos_r;
  assign cur_idle = item.first_byte ? 1'b0 : idle_r;
  assign idx_plus = {1'b0, idx_r} + 3'd1;

  always_comb begin
    pos_nxt      = pos_r;
    idle_nxt     = idle_r;
    rle_nxt      = rle_r;
    bpp_nxt      = bpp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pixels_nxt   = pixels_r;
    pkt_left_nxt = pkt_left_r;
    rep_nxt      = rep_r;
    idx_nxt      = idx_r;
    pix_nxt      = pix_r;
    res_vld      = 1'b0;
    res          = '0;
    cnt          = 8'd0;
    run          = 8'd0;
    pixels_after = pixels_r;

    if (step) begin
      if (item.first_byte) begin
        pos_nxt      = 5'd0;
        idle_nxt     = 1'b0;
        rle_nxt      = 1'b0;
        bpp_nxt      = 3'd0;
        pixels_nxt   = 32'd0;
        pkt_left_nxt = 8'd0;
        rep_nxt      = 1'b0;
        idx_nxt      = 2'd0;
      end
      if (!cur_idle) begin
        if (cur_pos < HDR_LEN) begin
          pos_nxt = cur_pos + 5'd1;
          case (cur_pos)
            POS_TYPE: begin
              if (b != TYPE_RAW && b != TYPE_RLE_RGB && b != TYPE_RLE_GRAY) begin
                res_vld        = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TYPE;
                idle_nxt       = 1'b1;
              end else begin
                rle_nxt = (b != TYPE_RAW);
              end
            end
            POS_WIDTH_LO:  width_nxt[7:0]   = b;
            POS_WIDTH_HI:  width_nxt[15:8]  = b;
            POS_HEIGHT_LO: height_nxt[7:0]  = b;
            POS_HEIGHT_HI: height_nxt[15:8] = b;
            POS_DEPTH: begin
              res_vld = 1'b1;
              if (b != DEPTH_8 && b != DEPTH_24 && b != DEPTH_32) begin
                res.kind       = KIND_ERROR;
                res.error_code = ERR_DEPTH;
                idle_nxt       = 1'b1;
              end else begin
                bpp_nxt          = b[5:3];
                pixels_nxt       = {16'd0, width_r} * {16'd0, height_r};
                pkt_left_nxt     = 8'd0;
                rep_nxt          = 1'b0;
                idx_nxt          = 2'd0;
                pix_nxt          = 24'd0;
                res.kind         = KIND_HEADER;
                res.image_width  = width_r;
                res.image_height = height_r;
                res.pixel_format = fmt_of(b[5:3]);
                // empty image: no pixel data follows
                if (width_r == 16'd0 || height_r == 16'd0) begin
                  res.last = 1'b1;
                  idle_nxt = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end else if (rle_r && pkt_left_r == 8'd0) begin
          // packet header byte
          cnt = {1'b0, b[6:0] & PKT_COUNT_MASK[6:0]} + 8'd1;
          if (pixels_r < {24'd0, cnt}) begin
            cnt = pixels_r[7:0];
          end
          pkt_left_nxt = cnt;
          rep_nxt      = |(b & PKT_REPEAT_MASK);
          idx_nxt      = 2'd0;
        end else if (idx_plus < bpp_r) begin
          case (idx_r)
            2'd0:    pix_nxt[7:0]   = b;
            2'd1:    pix_nxt[15:8]  = b;
            2'd2:    pix_nxt[23:16] = b;
            default: ;
          endcase
          idx_nxt = idx_plus[1:0];
        end else begin
          case (bpp_r)
            BPP_RGB: begin
              res.red   = b;
              res.green = pix_r[15:8];
              res.blue  = pix_r[7:0];
            end
            BPP_RGBA: begin
              res.red   = pix_r[23:16];
              res.green = pix_r[15:8];
              res.blue  = pix_r[7:0];
              res.alpha = b;
            end
            default: res.alpha = b;
          endcase
          idx_nxt = 2'd0;
          pix_nxt = 24'd0;
          if (rle_r && rep_r) begin
            run          = pkt_left_r;
            pkt_left_nxt = 8'd0;
          end else begin
            run = 8'd1;
            if (rle_r) begin
              pkt_left_nxt = pkt_left_r - 8'd1;
            end
          end
          if (pixels_r < {24'd0, run}) begin
            run = pixels_r[7:0];
          end
          pixels_after     = pixels_r - {24'd0, run};
          pixels_nxt       = pixels_after;
          res_vld          = 1'b1;
          res.kind         = KIND_RUN;
          res.image_width  = width_r;
          res.image_height = height_r;
          res.pixel_format = fmt_of(bpp_r);
          res.run_length   = run;
          res.last         = (pixels_after == 32'd0);
          if (pixels_after == 32'd0) begin
            idle_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 5'd0;
      idle_r     <= 1'b1;
      rle_r      <= 1'b0;
      bpp_r      <= 3'd0;
      pixels_r   <= 32'd0;
      pkt_left_r <= 8'd0;
      rep_r      <= 1'b0;
      idx_r      <= 2'd0;
    end else begin
      pos_r      <= pos_nxt;
      idle_r     <= idle_nxt;
      rle_r      <= rle_nxt;
      bpp_r      <= bpp_nxt;
      pixels_r   <= pixels_nxt;
      pkt_left_r <= pkt_left_nxt;
      rep_r      <= rep_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r  <= width_nxt;
    height_r <= height_nxt;
    pix_r    <= pix_nxt;
  end

  // header position never runs past the start of pixel data
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= HDR_LEN)
    else $error("header position past end of header");

  a_error_idles: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.kind == KIND_ERROR |=> idle_r)
    else $error("error result did not stop the stream");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.last |=> idle_r)
    else $error("last result did not stop the stream");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.kind == KIND_RUN |-> res.run_length != 8'd0)
    else $error("pixel run with zero length");

endmodule

`default_nettype wire

FILE: hdl/tgad_out_stage.sv
// result register of the tga stream decoder
`default_nettype none

module tgad_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire tgad_pkg::result_t  res,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output tgad_pkg::result_t       out_res
);
  import tgad_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tga_image_stream_decoder.sv
// tga stream decoder top level: takes file bytes, gives header, run and error results
//
// in_ channel: one file byte per transfer; in_first_byte marks the first byte of a
// new file and restarts header parsing at any time, even mid-image.
// out_ channel: at most one result per byte. a header result comes on header byte
// 16 (kind 0), an error result on a bad type or depth (kind 2), then one pixel run
// result per raw pixel or repeat packet (kind 1), with out_last on the final run or
// on the header result of an empty image. a taken byte goes into the input register;
// its result, if any, is loaded into the result register when the parser steps, which
// raises out_valid.
// throughput: one byte per cycle unless the receiver stalls; the input register and
// the result register are the only stages and the parse logic between them is a
// single pass. when the receiver stalls with a result waiting, the byte in the input
// register waits and in_ready drops once that register is full; bytes with no result
// still pass only while the result register is free or being drained.
// reset: rst_n synchronous, active low; the decoder then ignores bytes until one
// arrives with in_first_byte set.
`default_nettype none

module tga_image_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_first_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic             out_error_code,
  output logic [15:0]      out_image_width,
  output logic [15:0]      out_image_height,
  output logic [1:0]       out_pixel_format,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [7:0]       out_run_length,
  output logic             out_last
);
  import tgad_pkg::*;

  logic    item_vld;
  item_t   item;
  logic    advance;
  logic    res_vld;
  result_t res;
  result_t out_res;

  // the parser steps only when the result register can take a result
  assign advance = item_vld && (!out_valid || out_ready);

  tgad_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_file_byte  (in_file_byte),
    .in_first_byte (in_first_byte),
    .advance       (advance),
    .item_vld      (item_vld),
    .item          (item)
  );

  tgad_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  tgad_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_error_code   = out_res.error_code;
  assign out_image_width  = out_res.image_width;
  assign out_image_height = out_res.image_height;
  assign out_pixel_format = out_res.pixel_format;
  assign out_red          = out_res.red;
  assign out_green        = out_res.green;
  assign out_blue         = out_res.blue;
  assign out_alpha        = out_res.alpha;
  assign out_run_length   = out_res.run_length;
  assign out_last         = out_res.last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (!out_valid || out_ready))
    else $error("result would overwrite a waiting result");

  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> item_vld)
    else $error("result without a byte in the input register");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: dv/tga_decoder_checker.sv
// checker for the tga stream decoder: tracks file bytes, predicts results, compares them
module tga_decoder_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_first_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_kind,
  input  wire logic        out_error_code,
  input  wire logic [15:0] out_image_width,
  input  wire logic [15:0] out_image_height,
  input  wire logic [1:0]  out_pixel_format,
  input  wire logic [7:0]  out_red,
  input  wire logic [7:0]  out_green,
  input  wire logic [7:0]  out_blue,
  input  wire logic [7:0]  out_alpha,
  input  wire logic [7:0]  out_run_length,
  input  wire logic        out_last,
  output int               fail_total,
  output int               results_pending
);
  import tgad_pkg::*;

  // decoder state as seen from the byte stream
  logic [4:0]  hdr_pos;
  logic        rle_image;
  logic [2:0]  px_size;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [31:0] px_remaining;
  logic [7:0]  pkt_remaining;
  logic        pkt_is_repeat;
  logic [1:0]  px_byte_idx;
  logic [23:0] px_gather;
  logic        waiting_first;

  result_t expected_results[$];
  int      mismatches = 0;
  int      pending = 0;

  assign fail_total      = mismatches;
  assign results_pending = pending;

  function automatic logic [1:0] current_format();
    if (px_size == BPP_RGBA) return FMT_RGBA;
    if (px_size == BPP_RGB) return FMT_RGB;
    return FMT_ALPHA;
  endfunction

  task automatic clear_decoder();
    hdr_pos       = '0;
    rle_image     = 1'b0;
    px_size       = '0;
    img_w         = '0;
    img_h         = '0;
    px_remaining  = '0;
    pkt_remaining = '0;
    pkt_is_repeat = 1'b0;
    px_byte_idx   = '0;
    px_gather     = '0;
    waiting_first = 1'b1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fb);
    result_t     r;
    logic [4:0]  pos;
    logic [31:0] cnt;
    logic [31:0] run;
    r = '0;
    if (fb) begin
      clear_decoder();
      waiting_first = 1'b0;
    end
    if (!waiting_first && hdr_pos < HDR_LEN) begin
      pos = hdr_pos;
      hdr_pos = hdr_pos + 5'd1;
      case (pos)
        POS_TYPE: begin
          if (b != TYPE_RAW && b != TYPE_RLE_RGB && b != TYPE_RLE_GRAY) begin
            r.kind = KIND_ERROR;
            r.error_code = ERR_TYPE;
            waiting_first = 1'b1;
            expected_results.push_back(r);
          end else begin
            rle_image = (b != TYPE_RAW);
          end
        end
        POS_WIDTH_LO:  img_w[7:0]  = b;
        POS_WIDTH_HI:  img_w[15:8] = b;
        POS_HEIGHT_LO: img_h[7:0]  = b;
        POS_HEIGHT_HI: img_h[15:8] = b;
        POS_DEPTH: begin
          if (b != DEPTH_8 && b != DEPTH_24 && b != DEPTH_32) begin
            r.kind = KIND_ERROR;
            r.error_code = ERR_DEPTH;
            waiting_first = 1'b1;
          end else begin
            px_size       = b[5:3];
            px_remaining  = {16'd0, img_w} * {16'd0, img_h};
            pkt_remaining = '0;
            pkt_is_repeat = 1'b0;
            px_byte_idx   = '0;
            px_gather     = '0;
            r.kind         = KIND_HEADER;
            r.image_width  = img_w;
            r.image_height = img_h;
            r.pixel_format = current_format();
            if (px_remaining == 0) begin
              r.last = 1'b1;
              waiting_first = 1'b1;
            end
          end
          expected_results.push_back(r);
        end
        default: ;
      endcase
    end else if (!waiting_first) begin
      if (rle_image && pkt_remaining == 0) begin
        // packet header: count is clipped to what is left of the image
        cnt = {24'd0, b & PKT_COUNT_MASK} + 32'd1;
        if (cnt > px_remaining) cnt = px_remaining;
        pkt_remaining = cnt[7:0];
        pkt_is_repeat = ((b & PKT_REPEAT_MASK) != 0);
        px_byte_idx   = '0;
      end else if ({1'b0, px_byte_idx} + 3'd1 < px_size) begin
        px_gather = px_gather | ({16'd0, b} << (8 * px_byte_idx));
        px_byte_idx = px_byte_idx + 2'd1;
      end else begin
        r.kind         = KIND_RUN;
        r.image_width  = img_w;
        r.image_height = img_h;
        r.pixel_format = current_format();
        // file order is blue first, so red comes from the last color byte
        case (px_size)
          BPP_ALPHA: r.alpha = b;
          BPP_RGB: begin
            r.red   = b;
            r.green = px_gather[15:8];
            r.blue  = px_gather[7:0];
          end
          default: begin
            r.red   = px_gather[23:16];
            r.green = px_gather[15:8];
            r.blue  = px_gather[7:0];
            r.alpha = b;
          end
        endcase
        px_byte_idx = '0;
        px_gather   = '0;
        if (rle_image && pkt_is_repeat) begin
          run = {24'd0, pkt_remaining};
          pkt_remaining = '0;
        end else begin
          run = 32'd1;
          if (rle_image) pkt_remaining = pkt_remaining - 8'd1;
        end
        if (run > px_remaining) run = px_remaining;
        px_remaining = px_remaining - run;
        r.run_length = run[7:0];
        r.last = (px_remaining == 0);
        if (r.last) waiting_first = 1'b1;
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_decoder();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected, kind %0d", out_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("error_code", 16'(want.error_code), 16'(out_error_code));
          check_field("image_width", want.image_width, out_image_width);
          check_field("image_height", want.image_height, out_image_height);
          check_field("pixel_format", 16'(want.pixel_format), 16'(out_pixel_format));
          check_field("red", 16'(want.red), 16'(out_red));
          check_field("green", 16'(want.green), 16'(out_green));
          check_field("blue", 16'(want.blue), 16'(out_blue));
          check_field("alpha", 16'(want.alpha), 16'(out_alpha));
          check_field("run_length", 16'(want.run_length), 16'(out_run_length));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (in_valid && in_ready) decode_byte(in_file_byte, in_first_byte);
    end
    pending = expected_results.size();
  end

endmodule

FILE: dv/tga_image_stream_decoder_tb.sv
// testbench top for the tga stream decoder: file byte stimulus, flow control and verdict
module tga_image_stream_decoder_tb;
  import tgad_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 1700;
  localparam int LONG_HOLD   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_file_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic        out_error_code;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic [1:0]  out_pixel_format;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [7:0]  out_run_length;
  logic        out_last;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int image_bytes = 0;
  int fail_total;
  int results_pending;

  tga_image_stream_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_byte     (in_file_byte),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_pixel_format (out_pixel_format),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_run_length   (out_run_length),
    .out_last         (out_last)
  );

  tga_decoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_file_byte     (in_file_byte),
    .in_first_byte    (in_first_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_pixel_format (out_pixel_format),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_run_length   (out_run_length),
    .out_last         (out_last),
    .fail_total       (fail_total),
    .results_pending  (results_pending)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // called at a rising edge, returns at the edge where the transfer happened
  task automatic send_byte(input logic [7:0] b, input logic fb);
    logic took;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_file_byte  <= b;
    in_first_byte <= fb;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_pixel(input int bpp);
    repeat (bpp) send_byte(pick_byte(), 1'b0);
    image_bytes += bpp;
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  // header, then pixel data up to max_px pixels, then bytes past the image
  task automatic send_image(input logic [7:0] img_type, input logic [7:0] depth,
                            input logic [15:0] w, input logic [15:0] h,
                            input int hdr_bytes, input longint max_px, input int trailing);
    logic [7:0] hdr [18];
    longint     total;
    longint     sent;
    longint     n;
    int         cnt;
    logic       rep;
    int         bpp;
    for (int i = 0; i < 18; i++) hdr[i] = 8'($urandom);
    hdr[POS_TYPE]      = img_type;
    hdr[POS_WIDTH_LO]  = w[7:0];
    hdr[POS_WIDTH_HI]  = w[15:8];
    hdr[POS_HEIGHT_LO] = h[7:0];
    hdr[POS_HEIGHT_HI] = h[15:8];
    hdr[POS_DEPTH]     = depth;
    for (int i = 0; i < hdr_bytes; i++) send_byte(hdr[i], i == 0);
    image_bytes += hdr_bytes;
    if (hdr_bytes == 18
        && (img_type == TYPE_RAW || img_type == TYPE_RLE_RGB || img_type == TYPE_RLE_GRAY)
        && (depth == DEPTH_8 || depth == DEPTH_24 || depth == DEPTH_32)) begin
      bpp = int'(depth >> 3);
      total = w;
      total = total * h;
      if (total > max_px) total = max_px;
      sent = 0;
      while (sent < total) begin
        if (img_type == TYPE_RAW) begin
          send_pixel(bpp);
          sent++;
        end else begin
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          rep = $urandom_range(0, 1);
          send_byte({rep, 7'(cnt)}, 1'b0);
          image_bytes++;
          n = cnt + 1;
          if (n > total - sent) n = total - sent;
          if (rep) send_pixel(bpp);
          else repeat (n) send_pixel(bpp);
          sent += n;
        end
      end
    end
    repeat (trailing) send_byte(pick_byte(), 1'b0);
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin sender_idle_pct = 61; recv_stall_pct <= 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct <= 61; end
      default: begin sender_idle_pct = 12; recv_stall_pct <= 12; end
    endcase
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return TYPE_RAW;
      1:       return TYPE_RLE_RGB;
      default: return TYPE_RLE_GRAY;
    endcase
  endfunction

  function automatic logic [7:0] pick_depth();
    case ($urandom_range(0, 2))
      0:       return DEPTH_8;
      1:       return DEPTH_24;
      default: return DEPTH_32;
    endcase
  endfunction

  initial begin
    int          file_no;
    int          choice;
    logic [15:0] w;
    logic [15:0] h;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any first byte are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // unsupported type and depth
    send_image(8'h00, DEPTH_24, 16'd1, 16'd1, 3, 0, 0);
    send_image(8'hFF, DEPTH_24, 16'd1, 16'd1, 3, 0, 0);
    send_image(TYPE_RAW, 8'd16, 16'd1, 16'd1, 18, 0, 1);
    // empty image, then bytes that must be ignored
    send_image(TYPE_RLE_RGB, DEPTH_24, 16'd0, 16'd7, 18, 0, 2);
    // each depth in raw form
    send_image(TYPE_RAW, DEPTH_8, 16'd2, 16'd1, 18, 100, 0);
    send_image(TYPE_RAW, DEPTH_24, 16'd1, 16'd2, 18, 100, 0);
    send_image(TYPE_RAW, DEPTH_32, 16'd1, 16'd1, 18, 100, 2);
    // repeat packet of 128 over a 2 pixel image gets clipped
    send_image(TYPE_RLE_RGB, DEPTH_32, 16'd2, 16'd1, 18, 0, 0);
    send_byte(8'hFF, 1'b0);
    send_pixel(4);
    send_byte(8'h5A, 1'b0);
    // raw packet of 128 over a 2 pixel image
    send_image(TYPE_RLE_GRAY, DEPTH_8, 16'd2, 16'd1, 18, 0, 0);
    send_byte(8'h7F, 1'b0);
    send_pixel(1);
    send_pixel(1);
    // largest size, cut off by a restart
    send_image(TYPE_RAW, DEPTH_32, 16'hFFFF, 16'hFFFF, 18, 3, 0);
    send_image(TYPE_RLE_GRAY, DEPTH_24, 16'd3, 16'd2, 18, 100, 0);

    image_bytes = 0;
    file_no = 0;
    while (image_bytes < BYTE_TARGET) begin
      if (file_no % 6 == 0) set_phase((file_no / 6) % 4);
      if (file_no == 20 || file_no == 90) begin
        // hold the result side off while bytes keep coming
        sender_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        send_image(TYPE_RAW, DEPTH_24, 16'd6, 16'd6, 18, 100, 0);
      end
      choice = $urandom_range(0, 99);
      w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      if (choice < 8) begin
        send_noise($urandom_range(1, 6));
      end else if (choice < 14) begin
        send_image(pick_type(), pick_depth(), w, h, $urandom_range(1, 17), 0, 0);
      end else if (choice < 20) begin
        if ($urandom_range(0, 2) == 0) begin
          w = 16'($urandom);
          h = 16'($urandom);
        end
        send_image(pick_type(), pick_depth(), w, h, 18, $urandom_range(0, 4), 0);
      end else if (choice < 25) begin
        send_image(8'($urandom), 8'($urandom), w, h, 18, 100, 0);
      end else begin
        send_image(pick_type(), pick_depth(), w, h, 18, 100,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
      file_no++;
    end

    in_valid <= 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_total == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
